[rtl/iwf_pkg.sv]
package iwf_pkg;

   typedef enum logic [2:0] {
      CLS_VALID,
      CLS_ALLOW,
      CLS_INVAL,
      CLS_KANA,
      CLS_EXTEND
   } char_class_type;

   localparam int unsigned POINT_WIDTH = 21;

   localparam logic [POINT_WIDTH-1:0] MIDDLE_DOT = 21'h030FB;

   // one decoded request: a character, a decode error, or nothing, plus end-of-word info
   typedef struct packed {
      logic                   last;
      logic                   trunc;
      logic                   err;
      logic                   chr;
      logic [POINT_WIDTH-1:0] code;
   } iwf_msg_type;

endpackage

[rtl/iwf_if.sv]
interface iwf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       word_end;

   modport source(output valid, output text_byte, output word_end, input ready);
   modport sink(input valid, input text_byte, input word_end, output ready);
endinterface

interface iwf_rsp_if;
   logic valid;
   logic ready;
   logic is_word;

   modport source(output valid, output is_word, input ready);
   modport sink(input valid, input is_word, output ready);
endinterface

[rtl/iwf_front.sv]
module iwf_front (
   input  logic               clock,
   input  logic               reset,
   iwf_req_if.sink            req_ch,
   output logic               push_valid,
   output iwf_pkg::iwf_msg_type push_msg,
   input  logic               push_ready
);
   import iwf_pkg::*;

   logic [1:0]             pend_ff, pend_in;
   logic [1:0]             lead_ff, lead_in;
   logic [POINT_WIDTH-1:0] point_ff, point_in;
   logic                   ferr_ff, ferr_in;
   logic                   take;
   logic [7:0]             b;
   logic [POINT_WIDTH-1:0] full_point;
   logic                   bad_point;
   iwf_msg_type            msg;

   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid;
   assign take         = req_ch.valid && push_ready;
   assign b            = req_ch.text_byte;
   assign full_point   = {point_ff[POINT_WIDTH-7:0], b[5:0]};

   always_comb begin
      case (lead_ff)
         2'd1:    bad_point = full_point < 21'h00080;
         2'd2:    bad_point = full_point < 21'h00800;
         default: bad_point = full_point < 21'h10000;
      endcase
      if (full_point >= 21'h0D800 && full_point <= 21'h0DFFF) begin
         bad_point = 1'b1;
      end
      if (full_point > 21'h10FFFF) begin
         bad_point = 1'b1;
      end
   end

   always_comb begin
      pend_in  = pend_ff;
      lead_in  = lead_ff;
      point_in = point_ff;
      ferr_in  = ferr_ff;
      msg      = '0;
      if (!ferr_ff) begin
         if (pend_ff == 2'd0) begin
            if (b < 8'h80) begin
               msg.chr  = 1'b1;
               msg.code = {13'd0, b};
            end else if (b inside {[8'hC2:8'hDF]}) begin
               point_in = {16'd0, b[4:0]};
               pend_in  = 2'd1;
               lead_in  = 2'd1;
            end else if (b inside {[8'hE0:8'hEF]}) begin
               point_in = {17'd0, b[3:0]};
               pend_in  = 2'd2;
               lead_in  = 2'd2;
            end else if (b inside {[8'hF0:8'hF4]}) begin
               point_in = {18'd0, b[2:0]};
               pend_in  = 2'd3;
               lead_in  = 2'd3;
            end else begin
               ferr_in = 1'b1;
               msg.err = 1'b1;
            end
         end else if (b[7:6] != 2'b10) begin
            ferr_in = 1'b1;
            msg.err = 1'b1;
         end else begin
            pend_in  = pend_ff - 2'd1;
            point_in = full_point;
            if (pend_ff == 2'd1) begin
               point_in = '0;
               lead_in  = 2'd0;
               if (bad_point) begin
                  ferr_in = 1'b1;
                  msg.err = 1'b1;
               end else begin
                  msg.chr  = 1'b1;
                  msg.code = full_point;
               end
            end
         end
      end
      msg.last  = req_ch.word_end;
      msg.trunc = req_ch.word_end && !ferr_in && (pend_in != 2'd0);
   end

   assign push_msg = msg;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         lead_ff  <= '0;
         point_ff <= '0;
         ferr_ff  <= 1'b0;
      end else if (take) begin
         if (req_ch.word_end) begin
            pend_ff  <= '0;
            lead_ff  <= '0;
            point_ff <= '0;
            ferr_ff  <= 1'b0;
         end else begin
            pend_ff  <= pend_in;
            lead_ff  <= lead_in;
            point_ff <= point_in;
            ferr_ff  <= ferr_in;
         end
      end
   end

   a_pend_within_lead: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= lead_ff)
      else $error("pending count exceeds lead length");

endmodule

[rtl/iwf_queue.sv]
module iwf_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  iwf_pkg::iwf_msg_type push_msg,
   output logic                 push_ready,
   output logic                 pop_valid,
   output iwf_pkg::iwf_msg_type pop_msg,
   input  logic                 pop_ready
);
   import iwf_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   iwf_msg_type    mem_ff [DEPTH];
   logic [AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]  count_ff;
   logic           push, pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_msg    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_msg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count out of range");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("queue count did not advance on push");

endmodule

[rtl/iwf_back.sv]
module iwf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   input  iwf_pkg::iwf_msg_type pop_msg,
   output logic                 pop_ready,
   iwf_rsp_if.source            rsp_ch
);
   import iwf_pkg::*;

   logic           rej_ff, rej_in;
   logic [1:0]     cc_ff, cc_in;
   logic [1:0]     kc_ff, kc_in;
   logic           sv_ff, sv_in;
   logic           omd_ff, omd_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           is_word_ff, is_word_in;
   logic [1:0]     cc_inc;
   logic           pop;
   logic           ok;
   char_class_type cls;

   function automatic char_class_type classify(input logic [POINT_WIDTH-1:0] c);
      char_class_type k;
      if (c < 21'h80) begin
         if (c inside {[21'h30:21'h39], [21'h41:21'h5A], [21'h61:21'h7A]}) begin
            k = CLS_VALID;
         end else if (c inside {21'h21, [21'h23:21'h27], [21'h2B:21'h2F],
                                21'h3A, 21'h3F, 21'h40, 21'h5F}) begin
            k = CLS_ALLOW;
         end else begin
            k = CLS_INVAL;
         end
      end else if (c inside {21'h3005, [21'h309D:21'h309E], [21'h30FC:21'h30FE]}) begin
         k = CLS_EXTEND;
      end else if (c inside {[21'h0000:21'h024F], [21'h0370:21'h052F],
                             [21'h1E00:21'h1FFF], 21'h3007, [21'h30A0:21'h30FF],
                             [21'h31F0:21'h31FF], [21'h3400:21'h4DBF],
                             [21'h4E00:21'h9FFF], [21'hF900:21'hFAFF]}) begin
         k = CLS_VALID;
      end else if (c inside {[21'h3040:21'h309F]}) begin
         k = CLS_KANA;
      end else begin
         k = CLS_INVAL;
      end
      return k;
   endfunction

   assign pop_ready = !pop_msg.last || !rsp_valid_ff || rsp_ch.ready;
   assign pop       = pop_valid && pop_ready;
   assign cls       = classify(pop_msg.code);
   assign cc_inc    = (cc_ff == 2'd3) ? 2'd3 : cc_ff + 2'd1;

   always_comb begin
      rej_in = rej_ff;
      cc_in  = cc_ff;
      kc_in  = kc_ff;
      sv_in  = sv_ff;
      omd_in = omd_ff;
      if (!rej_ff) begin
         if (pop_msg.err) begin
            rej_in = 1'b1;
         end else if (pop_msg.chr) begin
            cc_in = cc_inc;
            if (cc_inc == 2'd1 && pop_msg.code == MIDDLE_DOT) begin
               omd_in = 1'b1;
            end
            case (cls)
               CLS_ALLOW: begin
               end
               CLS_EXTEND: begin
                  if (cc_inc == 2'd1) begin
                     rej_in = 1'b1;
                  end
                  sv_in = 1'b1;
               end
               CLS_VALID: begin
                  sv_in = 1'b1;
               end
               CLS_KANA: begin
                  sv_in = 1'b1;
                  if (kc_ff != 2'd3) begin
                     kc_in = kc_ff + 2'd1;
                  end
               end
               default: begin
                  rej_in = 1'b1;
               end
            endcase
         end
      end
      ok = !rej_in && !pop_msg.trunc && sv_in
           && !(cc_in == 2'd1 && kc_in == 2'd1)
           && !(cc_in == 2'd2 && kc_in == 2'd2)
           && !(cc_in == 2'd1 && omd_in);
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      is_word_in   = is_word_ff;
      if (pop && pop_msg.last) begin
         rsp_valid_in = 1'b1;
         is_word_in   = ok;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.is_word = is_word_ff;

   always_ff @(posedge clock) begin
      is_word_ff <= is_word_in;
      if (reset) begin
         rej_ff       <= 1'b0;
         cc_ff        <= '0;
         kc_ff        <= '0;
         sv_ff        <= 1'b0;
         omd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            if (pop_msg.last) begin
               rej_ff <= 1'b0;
               cc_ff  <= '0;
               kc_ff  <= '0;
               sv_ff  <= 1'b0;
               omd_ff <= 1'b0;
            end else begin
               rej_ff <= rej_in;
               cc_ff  <= cc_in;
               kc_ff  <= kc_in;
               sv_ff  <= sv_in;
               omd_ff <= omd_in;
            end
         end
      end
   end

   a_word_state_cleared: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_msg.last) |=> (cc_ff == 2'd0 && kc_ff == 2'd0 && !rej_ff && !sv_ff))
      else $error("word state not cleared after verdict");

   a_kana_within_chars: assert property (@(posedge clock) disable iff (reset)
      kc_ff <= cc_ff)
      else $error("kana count exceeds character count");

endmodule

[rtl/index_word_filter_core.sv]
// Path: a word-end request is written into the queue, then classified, and its verdict registered as rsp valid.
// Throughput: one byte request per cycle unless stalled; the front decoder, the queue and the classifier
// each move one request per cycle, and a held verdict stalls word ends and, once the queue fills, all requests.
// QUEUE_DEPTH sets how many decoded requests buffer between decoder and classifier.
// Reset (synchronous, active high) clears decoder, queue pointers, word state and
// the output valid; no clearing pass is needed.
module index_word_filter_core #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   iwf_req_if.sink   req_ch,
   iwf_rsp_if.source rsp_ch
);
   import iwf_pkg::*;

   logic        push_valid, push_ready;
   logic        pop_valid, pop_ready;
   iwf_msg_type push_msg, pop_msg;

   iwf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_msg   (push_msg),
      .push_ready (push_ready)
   );

   iwf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_msg   (push_msg),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_msg    (pop_msg),
      .pop_ready  (pop_ready)
   );

   iwf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_msg   (pop_msg),
      .pop_ready (pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule
